// ===== rtl/core/sta_pkg.sv =====
// ----------------------------------------------------------------------------
// sta_pkg
// Shared widths, operation codes and the command format passed from the
// front end through the command queue to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package sta_pkg;

  localparam int POS_W      = 10;
  localparam int VAL_W      = 16;
  localparam int FUNC_W     = 2;
  localparam int CFG_W      = 11;
  localparam int K_W        = 4;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef enum logic [FUNC_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    logic             err;
    logic [K_W-1:0]   k;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/sparse_table_range_argmin.sv =====
// ----------------------------------------------------------------------------
// sparse_table_range_argmin
// Range-minimum engine returning the rightmost position of the minimum.
// Transactions enter a two-entry command queue, so the input keeps flowing
// while the back end works or a result waits, until the queue is full. In
// the back end a query reads the table RAM, then the value RAM, and compares;
// a single-element range skips the table read and an error needs neither.
// A build streams one table entry per cycle through a three-stage pipeline
// of table read, value read and compare-write, draining between levels;
// later commands wait in the queue meanwhile. Level 0 of the table is
// implicit and never stored.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_table_range_argmin #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int LEVELS       = 11,
  parameter int VALUE_BITS   = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [sta_pkg::FUNC_W-1:0] func_i,
  input  logic [sta_pkg::POS_W-1:0]  position_i,
  input  logic [sta_pkg::VAL_W-1:0]  value_i,
  input  logic [sta_pkg::POS_W-1:0]  left_pos_i,
  input  logic [sta_pkg::POS_W-1:0]  right_pos_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [sta_pkg::CFG_W-1:0]  cfg_element_count_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [sta_pkg::POS_W-1:0]  min_index_o,
  output logic [sta_pkg::VAL_W-1:0]  min_value_o,
  output logic                      error_o
);

  import sta_pkg::*;

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  cmd_t             push_cmd, head_cmd;
  logic             push, pop, full, head_valid;
  logic [CNT_W-1:0] count;

  sta_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .LEVELS      (LEVELS)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .func_i             (func_i),
    .position_i         (position_i),
    .value_i            (value_i),
    .left_pos_i         (left_pos_i),
    .right_pos_i        (right_pos_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_element_count_i(cfg_element_count_i),
    .fifo_full_i        (full),
    .push_o             (push),
    .cmd_o              (push_cmd),
    .count_o            (count)
  );

  sta_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (full),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .valid_o(head_valid)
  );

  sta_back #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .LEVELS      (LEVELS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(head_valid),
    .cmd_i      (head_cmd),
    .cmd_pop_o  (pop),
    .count_i    (count),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .min_index_o(min_index_o),
    .min_value_o(min_value_o),
    .error_o    (error_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/sta_ram.sv =====
// ----------------------------------------------------------------------------
// sta_ram
// Generic RAM: one write port, two read ports sharing one enable, registered
// read data that holds while the enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module sta_ram #(
  parameter int   WIDTH = 16,
  parameter int   DEPTH = 1024,
  localparam int  AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// ===== rtl/core/sta_front.sv =====
// ----------------------------------------------------------------------------
// sta_front
// Input front end: accepts transactions, orders the query range, checks it,
// picks the table level and queues a command. Owns the element count
// register and the table-built flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sta_front #(
  parameter int  MAX_ELEMENTS = 1024,
  parameter int  LEVELS       = 11,
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [sta_pkg::FUNC_W-1:0] func_i,
  input  logic [sta_pkg::POS_W-1:0]  position_i,
  input  logic [sta_pkg::VAL_W-1:0]  value_i,
  input  logic [sta_pkg::POS_W-1:0]  left_pos_i,
  input  logic [sta_pkg::POS_W-1:0]  right_pos_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [sta_pkg::CFG_W-1:0]  cfg_element_count_i,
  input  logic                      fifo_full_i,
  output logic                      push_o,
  output sta_pkg::cmd_t             cmd_o,
  output logic [CNT_W-1:0]          count_o
);

  import sta_pkg::*;

  localparam int RST_COUNT = (MAX_ELEMENTS < 1024) ? MAX_ELEMENTS : 1024;

  logic             built_q, built_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             accept;
  logic             cfg_write;
  logic             keep;
  logic [POS_W-1:0] lo, hi;
  logic [POS_W:0]   len;
  logic [K_W-1:0]   k;
  cmd_t             cmd;

  assign in_ready_o  = !fifo_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_comb begin
    lo  = (left_pos_i > right_pos_i) ? right_pos_i : left_pos_i;
    hi  = (left_pos_i > right_pos_i) ? left_pos_i : right_pos_i;
    len = {1'b0, hi} - {1'b0, lo} + (POS_W+1)'(1);
    k   = '0;
    for (int b = 0; b <= POS_W; b++) begin
      if (len[b]) begin
        k = K_W'(b);
      end
    end
    if (32'(k) > LEVELS - 1) begin
      k = K_W'(LEVELS - 1);
    end

    cmd.op    = OP_QUERY;
    cmd.pos   = position_i;
    cmd.value = value_i;
    cmd.lo    = lo;
    cmd.hi    = hi;
    cmd.k     = k;
    cmd.err   = !built_q || (32'(hi) >= 32'(count_q)) || (32'(hi) >= MAX_ELEMENTS);

    case (func_i)
      OP_LOAD: begin
        cmd.op = OP_LOAD;
        keep   = 32'(position_i) < MAX_ELEMENTS;
      end
      OP_BUILD: begin
        cmd.op = OP_BUILD;
        keep   = 1'b1;
      end
      OP_QUERY: begin
        cmd.op = OP_QUERY;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    built_d = built_q;
    count_d = count_q;
    if (cfg_write) begin
      built_d = 1'b0;
      if (32'(cfg_element_count_i) > MAX_ELEMENTS) begin
        count_d = CNT_W'(MAX_ELEMENTS);
      end else begin
        count_d = CNT_W'(cfg_element_count_i);
      end
    end else if (accept && keep) begin
      if (cmd.op == OP_LOAD) begin
        built_d = 1'b0;
      end else if (cmd.op == OP_BUILD) begin
        built_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      built_q <= 1'b0;
      count_q <= CNT_W'(RST_COUNT);
    end else begin
      built_q <= built_d;
      count_q <= count_d;
    end
  end

  assign push_o  = accept && keep;
  assign cmd_o   = cmd;
  assign count_o = count_q;

endmodule

`default_nettype wire

// ===== rtl/core/sta_fifo.sv =====
// ----------------------------------------------------------------------------
// sta_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sta_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sta_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output sta_pkg::cmd_t cmd_o,
  output logic          valid_o
);

  import sta_pkg::*;

  cmd_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_PTR_W:0]   cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + FIFO_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + FIFO_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (FIFO_PTR_W+1)'(do_push) - (FIFO_PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sta_back.sv =====
// ----------------------------------------------------------------------------
// sta_back
// Back end: executes loads, runs the table build pipeline level by level,
// answers queries with two table reads (skipped for a single-element range)
// and a compare, and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sta_back #(
  parameter int  MAX_ELEMENTS = 1024,
  parameter int  LEVELS       = 11,
  parameter int  VALUE_BITS   = 16,
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  input  sta_pkg::cmd_t            cmd_i,
  output logic                     cmd_pop_o,
  input  logic [CNT_W-1:0]         count_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [sta_pkg::POS_W-1:0] min_index_o,
  output logic [sta_pkg::VAL_W-1:0] min_value_o,
  output logic                     error_o
);

  import sta_pkg::*;

  localparam int IDX_W     = $clog2(MAX_ELEMENTS);
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int TAB_DEPTH = (LEVELS - 1) * MAX_ELEMENTS;
  localparam int TAB_AW    = $clog2(TAB_DEPTH);
  localparam logic [TAB_AW-1:0] ROW_STRIDE = TAB_AW'(MAX_ELEMENTS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_QTAB   = 5'b00010,
    S_QCMP   = 5'b00100,
    S_BRUN   = 5'b01000,
    S_BDRAIN = 5'b10000
  } back_state_e;

  function automatic logic [TAB_AW-1:0] tab_addr(input logic [LVL_W-1:0] row,
                                                 input logic [IDX_W-1:0] col);
    return TAB_AW'(row) * ROW_STRIDE + TAB_AW'(col);
  endfunction

  back_state_e      state_q, state_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic [IDX_W-1:0] a_q, a_d, b_q, b_d;
  logic             p1_vld_q, p1_vld_d, p2_vld_q, p2_vld_d;
  logic [IDX_W-1:0] p1_idx_q, p1_idx_d, p1_a_q, p1_a_d, p1_b_q, p1_b_d;
  logic [IDX_W-1:0] p2_idx_q, p2_idx_d, p2_a_q, p2_a_d, p2_b_q, p2_b_d;
  logic             out_vld_q, out_vld_d;
  logic [POS_W-1:0] out_idx_q, out_idx_d;
  logic [VAL_W-1:0] out_val_q, out_val_d;
  logic             out_err_q, out_err_d;

  logic                  val_we, val_re;
  logic [IDX_W-1:0]      val_wa, val_ra_a, val_ra_b;
  logic [VALUE_BITS-1:0] val_wd, val_rd_a, val_rd_b;
  logic                  tab_we, tab_re;
  logic [TAB_AW-1:0]     tab_wa, tab_ra_a, tab_ra_b;
  logic [IDX_W-1:0]      tab_wd, tab_rd_a, tab_rd_b;

  logic             slot_free;
  logic [POS_W:0]   q_bpos;
  logic [IDX_W-1:0] q_lo, q_bstart;
  logic [LVL_W-1:0] q_row;
  logic [IDX_W-1:0] half;
  logic [IDX_W-1:0] s2_a, s2_b;
  logic             issue_last;
  logic [LVL_W:0]   lvl_nxt;
  logic             more_lvl;

  sta_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(MAX_ELEMENTS)
  ) u_value_ram (
    .clk_i    (clk_i),
    .we_i     (val_we),
    .waddr_i  (val_wa),
    .wdata_i  (val_wd),
    .re_i     (val_re),
    .raddr_a_i(val_ra_a),
    .raddr_b_i(val_ra_b),
    .rdata_a_o(val_rd_a),
    .rdata_b_o(val_rd_b)
  );

  sta_ram #(
    .WIDTH(IDX_W),
    .DEPTH(TAB_DEPTH)
  ) u_table_ram (
    .clk_i    (clk_i),
    .we_i     (tab_we),
    .waddr_i  (tab_wa),
    .wdata_i  (tab_wd),
    .re_i     (tab_re),
    .raddr_a_i(tab_ra_a),
    .raddr_b_i(tab_ra_b),
    .rdata_a_o(tab_rd_a),
    .rdata_b_o(tab_rd_b)
  );

  assign slot_free  = !out_vld_q || out_ready_i;
  assign q_lo       = IDX_W'(cmd_i.lo);
  assign q_bpos     = {1'b0, cmd_i.hi} + (POS_W+1)'(1) - ((POS_W+1)'(1) << cmd_i.k);
  assign q_bstart   = IDX_W'(q_bpos);
  assign q_row      = LVL_W'(cmd_i.k - K_W'(1));
  assign half       = IDX_W'(1) << (lvl_q - LVL_W'(1));
  assign s2_a       = (lvl_q == LVL_W'(1)) ? p1_a_q : tab_rd_a;
  assign s2_b       = (lvl_q == LVL_W'(1)) ? p1_b_q : tab_rd_b;
  assign issue_last = (32'(i_q) + (32'd1 << lvl_q)) == 32'(count_i);
  assign lvl_nxt    = {1'b0, lvl_q} + (LVL_W+1)'(1);
  assign more_lvl   = (32'(lvl_nxt) < LEVELS) && ((count_i >> lvl_nxt) != '0);

  always_comb begin
    state_d   = state_q;
    lvl_d     = lvl_q;
    i_d       = i_q;
    a_d       = a_q;
    b_d       = b_q;
    cmd_pop_o = 1'b0;

    out_vld_d = out_vld_q && !out_ready_i;
    out_idx_d = out_idx_q;
    out_val_d = out_val_q;
    out_err_d = out_err_q;

    val_we   = 1'b0;
    val_wa   = IDX_W'(cmd_i.pos);
    val_wd   = VALUE_BITS'(cmd_i.value);
    val_re   = 1'b0;
    val_ra_a = s2_a;
    val_ra_b = s2_b;
    tab_re   = 1'b0;
    tab_ra_a = tab_addr(q_row, q_lo);
    tab_ra_b = tab_addr(q_row, q_bstart);

    // build pipeline: issue, operand fetch, compare and write
    p1_vld_d = 1'b0;
    p1_idx_d = i_q;
    p1_a_d   = i_q;
    p1_b_d   = i_q + IDX_W'(1);
    p2_vld_d = p1_vld_q;
    p2_idx_d = p1_idx_q;
    p2_a_d   = s2_a;
    p2_b_d   = s2_b;
    if (p1_vld_q) begin
      val_re = 1'b1;
    end
    tab_we = p2_vld_q;
    tab_wa = tab_addr(lvl_q - LVL_W'(1), p2_idx_q);
    tab_wd = (val_rd_a < val_rd_b) ? p2_a_q : p2_b_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_LOAD: begin
              cmd_pop_o = 1'b1;
              val_we    = 1'b1;
            end
            OP_BUILD: begin
              cmd_pop_o = 1'b1;
              if ((count_i >> 1) != '0) begin
                lvl_d   = LVL_W'(1);
                i_d     = '0;
                state_d = S_BRUN;
              end
            end
            OP_QUERY: begin
              if (cmd_i.err) begin
                if (slot_free) begin
                  cmd_pop_o = 1'b1;
                  out_vld_d = 1'b1;
                  out_idx_d = '0;
                  out_val_d = '0;
                  out_err_d = 1'b1;
                end
              end else begin
                cmd_pop_o = 1'b1;
                if (cmd_i.k == '0) begin
                  a_d      = q_lo;
                  b_d      = q_lo;
                  val_re   = 1'b1;
                  val_ra_a = q_lo;
                  val_ra_b = q_lo;
                  state_d  = S_QCMP;
                end else begin
                  tab_re  = 1'b1;
                  state_d = S_QTAB;
                end
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      S_QTAB: begin
        a_d      = tab_rd_a;
        b_d      = tab_rd_b;
        val_re   = 1'b1;
        val_ra_a = tab_rd_a;
        val_ra_b = tab_rd_b;
        state_d  = S_QCMP;
      end
      S_QCMP: begin
        if (slot_free) begin
          out_vld_d = 1'b1;
          out_err_d = 1'b0;
          if (val_rd_a < val_rd_b) begin
            out_idx_d = POS_W'(a_q);
            out_val_d = VAL_W'(val_rd_a);
          end else begin
            out_idx_d = POS_W'(b_q);
            out_val_d = VAL_W'(val_rd_b);
          end
          state_d = S_IDLE;
        end
      end
      S_BRUN: begin
        p1_vld_d = 1'b1;
        if (lvl_q != LVL_W'(1)) begin
          tab_re   = 1'b1;
          tab_ra_a = tab_addr(lvl_q - LVL_W'(2), i_q);
          tab_ra_b = tab_addr(lvl_q - LVL_W'(2), i_q + half);
        end
        i_d = i_q + IDX_W'(1);
        if (issue_last) begin
          state_d = S_BDRAIN;
        end
      end
      S_BDRAIN: begin
        if (!p1_vld_q && !p2_vld_q) begin
          if (more_lvl) begin
            lvl_d   = LVL_W'(lvl_nxt);
            i_d     = '0;
            state_d = S_BRUN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      lvl_q     <= '0;
      i_q       <= '0;
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      lvl_q     <= lvl_d;
      i_q       <= i_d;
      p1_vld_q  <= p1_vld_d;
      p2_vld_q  <= p2_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    b_q       <= b_d;
    p1_idx_q  <= p1_idx_d;
    p1_a_q    <= p1_a_d;
    p1_b_q    <= p1_b_d;
    p2_idx_q  <= p2_idx_d;
    p2_a_q    <= p2_a_d;
    p2_b_q    <= p2_b_d;
    out_idx_q <= out_idx_d;
    out_val_q <= out_val_d;
    out_err_q <= out_err_d;
  end

  assign out_valid_o = out_vld_q;
  assign min_index_o = out_idx_q;
  assign min_value_o = out_val_q;
  assign error_o     = out_err_q;

endmodule

`default_nettype wire

// ===== dv/sparse_table_range_argmin_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_table_range_argmin_tb
// Self-checking bench for the range-argmin engine. A short directed table
// covers reset behavior, ties, reversed and out-of-range queries and stale
// tables; random rounds then reprogram the element count, load the store,
// build and query. Every result is scored in order against a local model of
// the argmin table, under shifting input gaps and output backpressure.
// ----------------------------------------------------------------------------

module sparse_table_range_argmin_tb;
  import sta_pkg::*;

  localparam int MAX_ELEMENTS = 1024;
  localparam int LEVELS       = 11;
  localparam int ROUNDS       = 9;
  localparam int ROUND_ITEMS  = 12;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int WAIT_LIMIT   = 60_000;
  localparam logic [FUNC_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  value;
    logic [POS_W-1:0]  lo;
    logic [POS_W-1:0]  hi;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic             err;
  } result_t;

  typedef struct {
    bit               is_cfg;
    logic [CFG_W-1:0] cfg;
    item_t            item;
    bit               fixed;
    result_t          answer;
  } row_t;

  localparam result_t FAULT = '{index: '0, value: '0, err: 1'b1};

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [FUNC_W-1:0] func_i = '0;
  logic [POS_W-1:0]  position_i = '0;
  logic [VAL_W-1:0]  value_i = '0;
  logic [POS_W-1:0]  left_pos_i = '0;
  logic [POS_W-1:0]  right_pos_i = '0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_element_count_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [POS_W-1:0]  min_index_o;
  logic [VAL_W-1:0]  min_value_o;
  logic              error_o;

  sparse_table_range_argmin DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .func_i             (func_i),
    .position_i         (position_i),
    .value_i            (value_i),
    .left_pos_i         (left_pos_i),
    .right_pos_i        (right_pos_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_element_count_i(cfg_element_count_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .min_index_o        (min_index_o),
    .min_value_o        (min_value_o),
    .error_o            (error_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // local copy of the engine state
  logic [VAL_W-1:0] store_q [MAX_ELEMENTS];
  bit               loaded [MAX_ELEMENTS];
  logic [POS_W-1:0] argmin_q [LEVELS][MAX_ELEMENTS];
  bit               built = 1'b0;
  int unsigned      span_count = MAX_ELEMENTS;

  result_t     answers_due [$];
  int          mismatches = 0;
  int          gap_pct = 9;
  int          stall_pct = 79;
  int unsigned cycles = 0;

  function automatic logic [POS_W-1:0] pick_right(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    return (store_q[a] < store_q[b]) ? a : b;
  endfunction

  function automatic void rebuild_argmin();
    int unsigned i;
    int unsigned j;
    for (i = 0; i < span_count; i++) argmin_q[0][i] = i[POS_W-1:0];
    for (j = 1; j < LEVELS && (1 << j) <= span_count; j++) begin
      for (i = 0; i + (1 << j) <= span_count; i++) begin
        argmin_q[j][i] = pick_right(argmin_q[j-1][i], argmin_q[j-1][i + (1 << (j - 1))]);
      end
    end
    built = 1'b1;
  endfunction

  function automatic bit rmq_step(input item_t it, output result_t ans);
    int unsigned lo;
    int unsigned hi;
    int unsigned len;
    int unsigned k;
    logic [POS_W-1:0] best;
    ans = '0;
    case (it.func)
      OP_LOAD: begin
        store_q[it.pos] = it.value;
        loaded[it.pos] = 1'b1;
        built = 1'b0;
        return 1'b0;
      end
      OP_BUILD: begin
        rebuild_argmin();
        return 1'b0;
      end
      OP_QUERY: begin
        lo = (it.lo < it.hi) ? it.lo : it.hi;
        hi = (it.lo < it.hi) ? it.hi : it.lo;
        if (!built || hi >= span_count) begin
          ans = FAULT;
          return 1'b1;
        end
        len = hi - lo + 1;
        k = 0;
        while (k + 1 < LEVELS && (1 << (k + 1)) <= len) k++;
        best = pick_right(argmin_q[k][lo], argmin_q[k][hi + 1 - (1 << k)]);
        ans.index = best;
        ans.value = store_q[best];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return VAL_W'($urandom_range(0, 3));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic report(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch (%s): want idx=%0d val=%h err=%b, got idx=%0d val=%h err=%b",
               $realtime, what, want.index, want.value, want.err,
               got.index, got.value, got.err);
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{index: min_index_o, value: min_value_o, err: error_o};
      if (answers_due.size() == 0) begin
        report("unexpected", '0, got);
      end else begin
        want = answers_due.pop_front();
        if (got.index !== want.index || got.value !== want.value || got.err !== want.err) begin
          report("field", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // call at a falling edge; returns at the falling edge after the transaction
  task automatic issue(input item_t it, input bit fixed, input result_t typed);
    result_t ans;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= it.func;
    position_i  <= it.pos;
    value_i     <= it.value;
    left_pos_i  <= it.lo;
    right_pos_i <= it.hi;
    do @(posedge clk_i); while (!in_ready_o);
    if (rmq_step(it, ans)) answers_due = {answers_due, (fixed ? typed : ans)};
    @(negedge clk_i);
  endtask

  task automatic settle();
    int spins;
    in_valid_i <= 1'b0;
    spins = 0;
    while (answers_due.size() != 0 && spins < WAIT_LIMIT) begin
      @(negedge clk_i);
      spins++;
    end
    repeat (LEVELS * (span_count + 4) + 40) @(negedge clk_i);
  endtask

  task automatic write_span(input logic [CFG_W-1:0] v);
    settle();
    cfg_valid_i         <= 1'b1;
    cfg_element_count_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    span_count = (v > MAX_ELEMENTS) ? MAX_ELEMENTS : v;
    built = 1'b0;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    row_t        plan [22];
    item_t       it;
    logic [CFG_W-1:0] span;
    int          round;
    int          count;
    int          sel;
    int unsigned p;

    plan = '{
      '{0, '0,    '{OP_QUERY,  0,    0,        0,    0},    1, FAULT},
      '{0, '0,    '{OP_UNUSED, 1023, 16'hFFFF, 1023, 1023}, 0, '0},
      '{0, '0,    '{OP_LOAD,   1023, 16'hFFFF, 0,    0},    0, '0},
      '{0, '0,    '{OP_QUERY,  0,    0,        1023, 1023}, 1, FAULT},
      '{1, 11'd4, '0,                                       0, '0},
      '{0, '0,    '{OP_LOAD,   0,    16'hFFFF, 0,    0},    0, '0},
      '{0, '0,    '{OP_LOAD,   1,    16'h0000, 0,    0},    0, '0},
      '{0, '0,    '{OP_LOAD,   2,    16'h0000, 0,    0},    0, '0},
      '{0, '0,    '{OP_LOAD,   3,    16'hFFFF, 0,    0},    0, '0},
      '{0, '0,    '{OP_BUILD,  0,    0,        0,    0},    0, '0},
      '{0, '0,    '{OP_QUERY,  0,    0,        0,    3},    0, '0},
      '{0, '0,    '{OP_QUERY,  0,    0,        3,    0},    0, '0},
      '{0, '0,    '{OP_QUERY,  0,    0,        0,    0},    0, '0},
      '{0, '0,    '{OP_QUERY,  0,    0,        3,    3},    0, '0},
      '{0, '0,    '{OP_QUERY,  0,    0,        0,    4},    1, FAULT},
      '{0, '0,    '{OP_QUERY,  0,    0,        1023, 0},    1, FAULT},
      '{0, '0,    '{OP_LOAD,   2,    16'h0005, 0,    0},    0, '0},
      '{0, '0,    '{OP_QUERY,  0,    0,        0,    3},    1, FAULT},
      '{0, '0,    '{OP_BUILD,  0,    0,        0,    0},    0, '0},
      '{0, '0,    '{OP_QUERY,  0,    0,        1,    3},    0, '0},
      '{0, '0,    '{OP_QUERY,  0,    0,        2,    1},    0, '0},
      '{0, '0,    '{OP_UNUSED, 0,    0,        0,    0},    0, '0}
    };

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[r]) begin
      if (plan[r].is_cfg) write_span(plan[r].cfg);
      else issue(plan[r].item, plan[r].fixed, plan[r].answer);
    end

    for (round = 0; round < ROUNDS; round++) begin
      if (round == ROUNDS / 3) begin
        gap_pct   = 79;
        stall_pct = 9;
      end else if (round == 2 * ROUNDS / 3) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      case (round)
        0:       span = 11'd1;
        1:       span = 11'd0;
        2:       span = 11'd2047;
        3:       span = 11'd2;
        5:       span = 11'd3;
        6:       span = 11'd1024;
        8:       span = 11'd1500;
        default: span = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(100, 1024))
                                                     : CFG_W'($urandom_range(1, 48));
      endcase
      write_span(span);
      count = 0;

      repeat ($urandom_range(2, 8)) begin
        it = '0;
        it.func  = OP_LOAD;
        it.pos   = (span_count > 0 && $urandom_range(0, 3) != 0)
                   ? POS_W'($urandom_range(0, span_count - 1))
                   : POS_W'($urandom_range(0, MAX_ELEMENTS - 1));
        it.value = rand_value();
        issue(it, 1'b0, '0);
        count++;
      end
      it = '0;
      it.func = OP_QUERY;
      it.hi   = POS_W'($urandom);
      issue(it, 1'b0, '0);
      count++;

      // fill gaps so the build never reads an empty slot
      for (p = 0; p < span_count; p++) begin
        if (!loaded[p]) begin
          it = '0;
          it.func  = OP_LOAD;
          it.pos   = p[POS_W-1:0];
          it.value = rand_value();
          issue(it, 1'b0, '0);
        end
      end
      it = '0;
      it.func = OP_BUILD;
      issue(it, 1'b0, '0);
      count++;

      while (count < ROUND_ITEMS) begin
        sel = $urandom_range(0, 99);
        it = '0;
        if (sel < 80 && span_count > 0) begin
          it.func = OP_QUERY;
          it.lo   = POS_W'($urandom_range(0, span_count - 1));
          case ($urandom_range(0, 3))
            0:       it.hi = it.lo;
            1: begin
              it.lo = '0;
              it.hi = POS_W'(span_count - 1);
            end
            default: it.hi = POS_W'($urandom_range(0, span_count - 1));
          endcase
          count++;
        end else if (sel < 90) begin
          it.func = OP_QUERY;
          it.lo   = POS_W'($urandom_range(0, MAX_ELEMENTS - 1));
          it.hi   = (span_count < MAX_ELEMENTS)
                    ? POS_W'($urandom_range(span_count, MAX_ELEMENTS - 1))
                    : POS_W'($urandom_range(0, MAX_ELEMENTS - 1));
          if ($urandom_range(0, 1)) {it.lo, it.hi} = {it.hi, it.lo};
          count++;
        end else if (sel < 94) begin
          it.pos   = POS_W'($urandom);
          it.lo    = POS_W'($urandom);
          it.hi    = POS_W'($urandom);
          it.value = VAL_W'($urandom);
          it.func  = OP_UNUSED;
        end else begin
          it.func  = OP_LOAD;
          it.pos   = (span_count > 0) ? POS_W'($urandom_range(0, span_count - 1))
                                      : POS_W'($urandom_range(0, MAX_ELEMENTS - 1));
          it.value = rand_value();
          count++;
          if ($urandom_range(0, 3) != 0) begin
            issue(it, 1'b0, '0);
            it = '0;
            it.func = OP_BUILD;
            count++;
          end
        end
        issue(it, 1'b0, '0);
      end
    end

    settle();
    while (answers_due.size() != 0) report("missing", answers_due.pop_front(), '0);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sparse_table_range_argmin.f =====
rtl/core/sta_pkg.sv
rtl/core/sta_ram.sv
rtl/core/sta_front.sv
rtl/core/sta_fifo.sv
rtl/core/sta_back.sv
rtl/core/sparse_table_range_argmin.sv
dv/sparse_table_range_argmin_tb.sv
